### rtl/core/sfq_pkg.sv
// ----------------------------------------------------------------------------
// sfq_pkg: shared types and constants of the searchable FIFO queue
// Command codes, status codes, controller states and the control word that
// the queue controller hands to every storage cell.
// ----------------------------------------------------------------------------
package sfq_pkg;

    // Width of one queue entry.
    localparam int DATA_W = 32;

    typedef logic signed [DATA_W-1:0] t_data;

    // Answer for a search that finds nothing, or a query on an empty queue.
    localparam t_data MINUS_ONE = t_data'(-1);

    // Command carried by one input beat.
    typedef enum logic [2:0] {
        MODE_PUSH         = 3'd0,
        MODE_POP          = 3'd1,
        MODE_FIND         = 3'd2,
        MODE_REMOVE_ALL   = 3'd3,
        MODE_REMOVE_FIRST = 3'd4,
        MODE_MAX          = 3'd5,
        MODE_MIN          = 3'd6
    } t_mode;

    // Status reported with every result.
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // Controller states.
    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_WALK = 2'd1,
        S_FIN  = 2'd2
    } t_state;

    // Per-cell control: load the pushed value, shift towards the front, or
    // take the recirculated front entry as the new tail.
    typedef struct packed {
        logic load_push;
        logic shift;
        logic load_tail;
    } t_cell_ctrl;

endpackage

### rtl/core/sfq_cmd_if.sv
// ----------------------------------------------------------------------------
// sfq_cmd_if: command channel of the searchable FIFO queue
// Valid/ready channel carrying one command and its operand per beat.
// ----------------------------------------------------------------------------
interface sfq_cmd_if import sfq_pkg::*;;

    logic        valid;
    logic        ready;
    logic [2:0]  mode;
    t_data       value;

    modport source (output valid, output mode, output value, input ready);
    modport sink   (input valid, input mode, input value, output ready);

endinterface

### rtl/core/sfq_res_if.sv
// ----------------------------------------------------------------------------
// sfq_res_if: result channel of the searchable FIFO queue
// Valid/ready channel carrying the queue summary and the command answer.
// ----------------------------------------------------------------------------
interface sfq_res_if import sfq_pkg::*;;

    logic        valid;
    logic        ready;
    t_data       front_value;
    t_data       last_value;
    logic [4:0]  item_count;
    logic        is_empty;
    t_data       answer;
    logic        found;
    logic [1:0]  status;

    modport source (
        output valid, output front_value, output last_value, output item_count,
        output is_empty, output answer, output found, output status,
        input  ready
    );
    modport sink (
        input  valid, input front_value, input last_value, input item_count,
        input  is_empty, input answer, input found, input status,
        output ready
    );

endinterface

### rtl/core/searchable_fifo_queue_unit.sv
// ----------------------------------------------------------------------------
// searchable_fifo_queue_unit: FIFO of signed entries with search and delete
// Commands arrive on i_cmd (push, pop, find, remove all, remove first, max,
// min) and each one yields exactly one result beat on o_res, which reports the
// front, the tail, the count, the empty flag, the answer, found and status.
//
// The entries sit in a chain of QUEUE_DEPTH cells with the front in cell 0.
// Push and pop go from the accepted command beat through the S_FIN state to
// the output register. Find, remove and max/min walk the chain: every cycle
// the front entry is examined and either fed back to the tail or dropped, so
// such a command visits every live entry in S_WALK before it reaches S_FIN.
// The walk moves one entry per cycle through the cell chain. One command is
// in flight at a time; a command on an empty queue goes straight to S_FIN.
//
// The result sits in an output register; the next command is accepted while
// that result waits only once its slot is being freed, so a stalled receiver
// holds off i_cmd.ready. Reset (i_rst_n low, synchronous) empties the queue
// and drops any pending result; the entry contents are not cleared.
// ----------------------------------------------------------------------------
module searchable_fifo_queue_unit import sfq_pkg::*; #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    sfq_cmd_if.sink   i_cmd,
    sfq_res_if.source o_res
);

    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);
    localparam logic [CW-1:0] ONE_C   = CW'(1);

    // Controller state.
    t_state         r_state, n_state;
    logic [CW-1:0]  r_count, n_count;
    logic [CW-1:0]  r_step,  n_step;
    logic [CW-1:0]  r_work,  n_work;
    t_data          r_last,  n_last;
    t_mode          r_mode,  n_mode;
    t_data          r_key,   n_key;
    t_data          r_answer, n_answer;
    logic           r_found, n_found;
    t_status        r_status, n_status;

    // Output register.
    logic           r_ovalid;
    t_data          r_ofront;
    t_data          r_olast;
    logic [4:0]     r_ocount;
    logic           r_oempty;
    t_data          r_oanswer;
    logic           r_ofound;
    logic [1:0]     r_ostatus;

    // Cell chain.
    t_data          w_cell [QUEUE_DEPTH];
    t_cell_ctrl     w_ctrl [QUEUE_DEPTH];
    logic           push_en;
    logic           shift_en;
    logic           tail_en;
    logic [CW-1:0]  tail_pos;
    t_data          front;
    logic           match;
    logic           keep;
    logic           walk_start;
    logic           walk_last;
    logic           cmd_fire;
    t_mode          cmd_mode;

    assign cmd_mode  = t_mode'(i_cmd.mode);
    assign i_cmd.ready = (r_state == S_IDLE) && (!r_ovalid || o_res.ready);
    assign cmd_fire  = i_cmd.valid && i_cmd.ready;
    assign front     = w_cell[0];
    assign match     = (front == r_key);
    assign walk_last = (r_step == (r_count - ONE_C));
    assign tail_pos  = r_work - ONE_C;

    // Command decode and walk datapath.
    always_comb begin
        n_count    = r_count;
        n_step     = r_step;
        n_work     = r_work;
        n_last     = r_last;
        n_mode     = r_mode;
        n_key      = r_key;
        n_answer   = r_answer;
        n_found    = r_found;
        n_status   = r_status;
        push_en    = 1'b0;
        shift_en   = 1'b0;
        tail_en    = 1'b0;
        keep       = 1'b1;
        walk_start = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (cmd_fire) begin
                    n_mode   = cmd_mode;
                    n_key    = i_cmd.value;
                    n_answer = '0;
                    n_found  = 1'b0;
                    n_status = ST_OK;
                    n_step   = '0;
                    n_work   = r_count;
                    case (cmd_mode)
                        MODE_PUSH: begin
                            if (r_count == DEPTH_C) begin
                                n_status = ST_FULL;
                            end else begin
                                push_en = 1'b1;
                                n_count = r_count + ONE_C;
                                n_last  = i_cmd.value;
                            end
                        end
                        MODE_POP: begin
                            if (r_count == '0) begin
                                n_status = ST_EMPTY;
                            end else begin
                                shift_en = 1'b1;
                                n_count  = r_count - ONE_C;
                            end
                        end
                        MODE_FIND, MODE_MAX, MODE_MIN: begin
                            n_answer = MINUS_ONE;
                            if (r_count == '0) begin
                                n_status = ST_EMPTY;
                            end else begin
                                walk_start = 1'b1;
                            end
                        end
                        MODE_REMOVE_ALL, MODE_REMOVE_FIRST: begin
                            if (r_count == '0) begin
                                n_status = ST_EMPTY;
                            end else begin
                                walk_start = 1'b1;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_WALK: begin
                shift_en = 1'b1;
                case (r_mode)
                    MODE_REMOVE_ALL:   keep = !match;
                    MODE_REMOVE_FIRST: keep = !(match && !r_found);
                    default:           keep = 1'b1;
                endcase
                tail_en = keep;
                if (keep) begin
                    n_last = front;
                end else begin
                    n_work = r_work - ONE_C;
                end
                case (r_mode)
                    MODE_FIND: begin
                        if (match && !r_found) begin
                            n_answer = t_data'(r_step);
                        end
                        n_found = r_found || match;
                    end
                    MODE_REMOVE_ALL, MODE_REMOVE_FIRST: begin
                        n_found = r_found || match;
                    end
                    MODE_MAX: begin
                        if ((r_step == '0) || (front > r_answer)) begin
                            n_answer = front;
                        end
                    end
                    MODE_MIN: begin
                        if ((r_step == '0) || (front < r_answer)) begin
                            n_answer = front;
                        end
                    end
                    default: begin
                    end
                endcase
                n_step = r_step + ONE_C;
                if (walk_last) begin
                    n_count = n_work;
                end
            end
            default: begin
            end
        endcase
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (cmd_fire) begin
                    n_state = walk_start ? S_WALK : S_FIN;
                end
            end
            S_WALK: begin
                if (walk_last) begin
                    n_state = S_FIN;
                end
            end
            S_FIN:   n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    // Working registers of the current command.
    always_ff @(posedge i_clk) begin
        r_step   <= n_step;
        r_work   <= n_work;
        r_last   <= n_last;
        r_mode   <= n_mode;
        r_key    <= n_key;
        r_answer <= n_answer;
        r_found  <= n_found;
        r_status <= n_status;
    end

    // Cell chain: the last cell refills from itself, its content beyond the
    // live window is never read.
    for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
        assign w_ctrl[g].load_push = push_en && (r_count == CW'(g));
        assign w_ctrl[g].shift     = shift_en;
        assign w_ctrl[g].load_tail = tail_en && (tail_pos == CW'(g));

        sfq_cell u_cell (
            .i_clk         (i_clk),
            .i_ctrl        (w_ctrl[g]),
            .i_push_value  (i_cmd.value),
            .i_tail_value  (front),
            .i_right_value (w_cell[(g + 1 < QUEUE_DEPTH) ? g + 1 : g]),
            .o_value       (w_cell[g])
        );
    end

    // Result beat valid: set when a command finishes, cleared when taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (r_state == S_FIN) begin
            r_ovalid <= 1'b1;
        end else if (o_res.ready) begin
            r_ovalid <= 1'b0;
        end
    end

    // Result payload, built from the settled queue state.
    always_ff @(posedge i_clk) begin
        if (r_state == S_FIN) begin
            r_ofront  <= (r_count == '0) ? '0 : front;
            r_olast   <= (r_count == '0) ? '0 : r_last;
            r_ocount  <= 5'(r_count);
            r_oempty  <= (r_count == '0);
            r_oanswer <= r_answer;
            r_ofound  <= r_found;
            r_ostatus <= r_status;
        end
    end

    assign o_res.valid       = r_ovalid;
    assign o_res.front_value = r_ofront;
    assign o_res.last_value  = r_olast;
    assign o_res.item_count  = r_ocount;
    assign o_res.is_empty    = r_oempty;
    assign o_res.answer      = r_oanswer;
    assign o_res.found       = r_ofound;
    assign o_res.status      = r_ostatus;

    // The fill level never passes the depth.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= DEPTH_C)
        else $error("queue count exceeds depth");

    // A walk never runs past the live entries.
    a_walk_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK) |-> (r_step < r_count) && (r_work <= r_count)
            && (r_work != '0))
        else $error("walk left the live window");

    // Finishing a command always presents a result beat next cycle.
    a_fin_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN) |=> r_ovalid)
        else $error("finished command gave no result");

    // A finishing command never overwrites a result still waiting.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN) |-> !r_ovalid || o_res.ready)
        else $error("result overwritten before it was taken");

    // The empty flag agrees with the reported count.
    a_empty_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid |-> (r_oempty == (r_ocount == 5'd0)))
        else $error("empty flag disagrees with count");

endmodule

### rtl/core/sfq_cell.sv
// ----------------------------------------------------------------------------
// sfq_cell: one storage cell of the queue chain
// Holds one entry. Cell 0 is the queue front; every shift moves each entry
// one cell towards the front, and the walk writes kept entries back at the tail.
// ----------------------------------------------------------------------------
module sfq_cell import sfq_pkg::*; (
    input  logic       i_clk,
    input  t_cell_ctrl i_ctrl,
    input  t_data      i_push_value,
    input  t_data      i_tail_value,
    input  t_data      i_right_value,
    output t_data      o_value
);

    t_data r_value;
    t_data n_value;

    // A push writes the cell at the tail; a shift takes the neighbour's entry
    // unless this cell is where the recirculated front entry lands.
    always_comb begin
        n_value = r_value;
        if (i_ctrl.load_push) begin
            n_value = i_push_value;
        end else if (i_ctrl.shift) begin
            n_value = i_ctrl.load_tail ? i_tail_value : i_right_value;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value = r_value;

endmodule
